[sv/bls_pkg.sv]
// Shared types and constants for the bounded LIFO stack.
package bls_pkg;

    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 5;
    localparam int DEPTH_DEF  = 16;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_DUMP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_DOWN   = 2'd1,
        CELL_UP     = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
    } cell_ctrl_t;

endpackage

[sv/bounded_lifo_stack_top.sv]
// Top level of the bounded LIFO stack: controller and a row of shifting cells.
//
// Requests enter on the s_ stream: s_tuser carries the operation (push, pop,
// peek, dump) and s_tdata the signed word to push. Results leave on the m_
// stream: m_tuser carries the status, m_tdata the word and the fill count,
// m_tlast marks the final result of a request.
// The words sit in a row of DEPTH cells with the top of stack in cell 0;
// push shifts the row down, pop shifts it up.
// Push, pop and peek: the result is registered and valid in the cycle after
// acceptance; one request per cycle while the receiver keeps up.
// Dump: the controller moves to the dump state, then gives one result per
// cycle for each stored word while the receiver keeps up, as the row rotates
// up by one with each result and ends as it began; no request is taken during
// that time. An empty dump gives one result with empty status.
// Reset clears the fill count and the output valid; cell contents are left
// as they are and never read before being written.
// A stalled receiver holds the result register; s_tready drops until the
// result is taken.
module bounded_lifo_stack_top #(
    parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bls_pkg::WORD_W-1:0]          s_tdata,   // push_value
    input  logic [1:0]                          s_tuser,   // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bls_pkg::M_TDATA_W-1:0]       m_tdata,   // word, count, zero pad
    output logic [1:0]                          m_tuser,   // status
    output logic                                m_tlast
);
    import bls_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [WORD_W-1:0] words [DEPTH];
    logic signed [WORD_W-1:0] push_value;
    logic signed [WORD_W-1:0] m_word;
    logic [COUNT_W-1:0]       m_count;
    logic [CW-1:0]            count;
    logic [CW-1:0]            rot_end;
    cell_ctrl_t               cell_ctrl;
    status_t                  m_status;
    op_t                      op;

    assign push_value = s_tdata;
    assign op         = op_t'(s_tuser);
    assign rot_end    = count - CW'(1);

    bls_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .op         (op),
        .push_value (push_value),
        .top_word   (words[0]),
        .cell_ctrl  (cell_ctrl),
        .count_o    (count),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_status   (m_status),
        .m_word     (m_word),
        .m_count    (m_count),
        .m_last     (m_tlast)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [WORD_W-1:0] above;
        logic signed [WORD_W-1:0] below;
        if (i == 0) begin : g_first
            assign above = push_value;
        end else begin : g_mid
            assign above = words[i-1];
        end
        if (i == DEPTH - 1) begin : g_end
            assign below = words[i];
        end else begin : g_inner
            assign below = words[i+1];
        end
        bls_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .wrap       (rot_end == CW'(i)),
            .above_word (above),
            .below_word (below),
            .top_word   (words[0]),
            .word_o     (words[i])
        );
    end

    assign m_tdata = {(M_TDATA_W - WORD_W - COUNT_W)'(0), m_count, m_word};
    assign m_tuser = m_status;

endmodule

[sv/bls_cell.sv]
// One stack cell: holds a word and moves it to or from its neighbors.
module bls_cell (
    input  logic                                aclk,
    input  bls_pkg::cell_ctrl_t                 ctrl,
    input  logic                                wrap,
    input  logic signed [bls_pkg::WORD_W-1:0]   above_word,
    input  logic signed [bls_pkg::WORD_W-1:0]   below_word,
    input  logic signed [bls_pkg::WORD_W-1:0]   top_word,
    output logic signed [bls_pkg::WORD_W-1:0]   word_o
);
    import bls_pkg::*;

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;

    always_comb begin
        case (ctrl.cmd)
            CELL_DOWN:   word_next = above_word;
            CELL_UP:     word_next = below_word;
            CELL_ROTATE: word_next = wrap ? top_word : below_word;
            default:     word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word_o = word_reg;

endmodule

[sv/bls_ctrl.sv]
// Stack controller: fill count, dump sequencing and the result register.
module bls_ctrl #(
    parameter int DEPTH = bls_pkg::DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  bls_pkg::op_t                        op,
    input  logic signed [bls_pkg::WORD_W-1:0]   push_value,
    input  logic signed [bls_pkg::WORD_W-1:0]   top_word,
    output bls_pkg::cell_ctrl_t                 cell_ctrl,
    output logic [CW-1:0]                       count_o,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output bls_pkg::status_t                    m_status,
    output logic signed [bls_pkg::WORD_W-1:0]   m_word,
    output logic [bls_pkg::COUNT_W-1:0]         m_count,
    output logic                                m_last
);
    import bls_pkg::*;

    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          rem_reg, rem_next;
    logic                   valid_reg, valid_next;
    status_t                status_reg, status_next;
    logic signed [WORD_W-1:0] word_reg, word_next;
    logic                   last_reg, last_next;
    logic [COUNT_W-1:0]     ocount_reg, ocount_next;

    logic free, accept, full, empty, load;

    assign free     = !valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && free;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == FULL);
    assign empty    = (count_reg == '0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && op == OP_DUMP && !empty) begin
                    state_next = S_DUMP;
                end
            end
            S_DUMP: begin
                if (free && rem_reg == ONE) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cell_ctrl.cmd = CELL_HOLD;
        count_next    = count_reg;
        rem_next      = rem_reg;
        load          = 1'b0;
        status_next   = ST_OK;
        word_next     = '0;
        last_next     = 1'b1;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    load = 1'b1;
                    case (op)
                        OP_PUSH: begin
                            if (full) begin
                                status_next = ST_OVERFLOW;
                            end else begin
                                cell_ctrl.cmd = CELL_DOWN;
                                word_next     = push_value;
                                count_next    = count_reg + ONE;
                            end
                        end
                        OP_POP: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                cell_ctrl.cmd = CELL_UP;
                                word_next     = top_word;
                                count_next    = count_reg - ONE;
                            end
                        end
                        OP_PEEK: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                word_next = top_word;
                            end
                        end
                        default: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                load     = 1'b0;
                                rem_next = count_reg;
                            end
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (free) begin
                    load          = 1'b1;
                    cell_ctrl.cmd = CELL_ROTATE;
                    word_next     = top_word;
                    last_next     = (rem_reg == ONE);
                    rem_next      = rem_reg - ONE;
                end
            end
            default: ;
        endcase
        ocount_next = COUNT_W'(count_next);
        valid_next  = load ? 1'b1 : (valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= status_next;
            word_reg   <= word_next;
            last_reg   <= last_next;
            ocount_reg <= ocount_next;
        end
    end

    assign count_o  = count_reg;
    assign m_tvalid = valid_reg;
    assign m_status = status_reg;
    assign m_word   = word_reg;
    assign m_count  = ocount_reg;
    assign m_last   = last_reg;

endmodule
